// ----- sv/sgm_pkg.sv -----
`default_nettype none
package sgm_pkg;

    // fraction bits of the ratio min/max used by the angle search
    localparam int FRAC_BITS  = 48;
    localparam int QW         = FRAC_BITS + 1;
    localparam int OCT_MAX    = 720;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int SQRT_STEPS = 11;
    localparam int SRCH_BITS  = 10;

    localparam logic [11:0] DIR_HALF    = 12'd2880;
    localparam logic [11:0] DIR_QUARTER = 12'd1440;
    localparam logic [11:0] HEIGHT_MAX  = 12'd2048;

    typedef logic [8:0][7:0] t_win;
    typedef logic [QW-1:0] t_tan_tab [0:OCT_MAX];

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       upd;
        logic       prep;
        logic       div;
        logic       fix;
        logic       addr;
        logic       cmp;
        logic       dir;
        logic       load;
        logic [5:0] step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic out_free;
    } t_sts;

    // tan((k - 1/2) / 16 degree) scaled by 2^FRAC_BITS, rounded down;
    // a ratio at or above entry k rounds to k sixteenths or more
    function automatic t_tan_tab build_tan_tab();
        t_tan_tab tab;
        real      ang;
        real      v;
        tab[0] = '0;
        for (int k = 1; k <= OCT_MAX; k++) begin
            ang = (real'(k) - 0.5) / 16.0 * 3.14159265358979323846 / 180.0;
            v = $floor($tan(ang) * (2.0 ** FRAC_BITS));
            tab[k] = QW'(longint'(v));
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

// ----- sv/sgm_ctrl.sv -----
`default_nettype none
module sgm_ctrl
    import sgm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_PREP, S_DIV, S_FIX, S_ADDR, S_CMP, S_DIR, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_step, n_step;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = i_sts.emit ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                if (r_step == 6'(DIV_STEPS - 1)) begin
                    n_state = S_FIX;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            S_FIX: begin
                n_state = S_ADDR;
                n_step  = 6'(SRCH_BITS - 1);
            end
            S_ADDR: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_step == '0) begin
                    n_state = S_DIR;
                end else begin
                    n_state = S_ADDR;
                    n_step  = r_step - 6'd1;
                end
            end
            S_DIR: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.step    = r_step;
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.upd     = (r_state == S_UPD);
        o_cmd.prep    = (r_state == S_PREP);
        o_cmd.div     = (r_state == S_DIV);
        o_cmd.fix     = (r_state == S_FIX);
        o_cmd.addr    = (r_state == S_ADDR);
        o_cmd.cmp     = (r_state == S_CMP);
        o_cmd.dir     = (r_state == S_DIR);
        o_cmd.load    = (r_state == S_OUT) && i_sts.out_free;
    end

endmodule
`default_nettype wire

// ----- sv/sgm_dp.sv -----
`default_nettype none
module sgm_dp
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [7:0]  i_pixel,
    input  wire logic        i_drain,
    input  wire logic        i_cfg_wr,
    input  wire logic        i_cfg_idx,
    input  wire logic [11:0] i_cfg_data,
    output logic [11:0]      o_frame_width,
    output logic [11:0]      o_frame_height,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [10:0]      o_magnitude,
    output logic [11:0]      o_direction,
    output logic             o_frame_end
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (CW > 12) ? CW : 12;
    localparam t_tan_tab TAN_TAB = build_tan_tab();

    // configuration
    logic [11:0] r_fw, r_fh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 12'd640;
            r_fh <= 12'd480;
        end else if (i_cfg_wr) begin
            if (i_cfg_idx) r_fh <= i_cfg_data;
            else           r_fw <= i_cfg_data;
        end
    end
    assign o_frame_width  = r_fw;
    assign o_frame_height = r_fh;

    // effective frame size
    logic [CMPW-1:0] w_eff;
    logic [11:0]     h_eff;
    logic [12:0]     h_p1;
    always_comb begin
        if (r_fw == '0)                          w_eff = CMPW'(1);
        else if (CMPW'(r_fw) > CMPW'(MAX_WIDTH)) w_eff = CMPW'(MAX_WIDTH);
        else                                     w_eff = CMPW'(r_fw);
        if (r_fh == '0)              h_eff = 12'd1;
        else if (r_fh > HEIGHT_MAX)  h_eff = HEIGHT_MAX;
        else                         h_eff = r_fh;
        h_p1 = {1'b0, h_eff} + 13'd1;
    end

    // position counters and window
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    t_win          r_win;
    logic [CW-1:0] c_eff;
    assign c_eff = (CMPW'(r_col) >= w_eff) ? '0 : r_col;

    // line stores, read at accept, written on update
    logic [7:0]    up_mem [MAX_WIDTH];
    logic [7:0]    lo_mem [MAX_WIDTH];
    logic [7:0]    r_up_q, r_lo_q, r_pix;
    logic          r_drain;
    logic [AW-1:0] r_addr;
    logic [7:0]    top, mid, bot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_up_q  <= up_mem[c_eff[AW-1:0]];
            r_lo_q  <= lo_mem[c_eff[AW-1:0]];
            r_pix   <= i_pixel;
            r_drain <= i_drain;
            r_addr  <= c_eff[AW-1:0];
        end
    end

    // window update for one item
    logic    pre, fend, post;
    t_win    win_a, win_b, win_n, win_e;
    logic [CW-1:0] col_p1;
    always_comb begin
        pre  = (c_eff == '0) && (r_row >= 12'd2);
        fend = pre && ({1'b0, r_row} >= h_p1);
        post = (c_eff != '0) && (r_row >= 12'd1);
        top  = (r_row >= 12'd2) ? r_up_q : 8'd0;
        mid  = (r_row >= 12'd1) ? r_lo_q : 8'd0;
        bot  = (r_row < h_eff && !r_drain) ? r_pix : 8'd0;
        win_a = r_win;
        if (pre) begin
            for (int k = 0; k < 3; k++) begin
                win_a[k*3]   = r_win[k*3+1];
                win_a[k*3+1] = r_win[k*3+2];
                win_a[k*3+2] = 8'd0;
            end
        end
        win_b = (c_eff == '0) ? '0 : win_a;
        win_n = win_b;
        for (int k = 0; k < 3; k++) begin
            win_n[k*3]   = win_b[k*3+1];
            win_n[k*3+1] = win_b[k*3+2];
        end
        win_n[2] = top;
        win_n[5] = mid;
        win_n[8] = bot;
        win_e  = pre ? win_a : win_n;
        col_p1 = c_eff + CW'(1);
    end
    assign o_sts.emit = pre || post;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && !fend) begin
            up_mem[r_addr] <= mid;
            lo_mem[r_addr] <= bot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
        end else if (i_cmd.upd) begin
            if (fend) begin
                r_col <= '0;
                r_row <= '0;
                r_win <= '0;
            end else begin
                r_win <= win_n;
                if (CMPW'(col_p1) >= w_eff) begin
                    r_col <= '0;
                    r_row <= r_row + 12'd1;
                end else begin
                    r_col <= col_p1;
                end
            end
        end
    end

    // Sobel sums of the emitted window
    logic [9:0]        sxa, sxb, sya, syb;
    logic signed [10:0] r_gx, r_gy;
    logic               r_fend;
    always_comb begin
        sxa = 10'(win_e[0]) + {1'b0, win_e[3], 1'b0} + 10'(win_e[6]);
        sxb = 10'(win_e[2]) + {1'b0, win_e[5], 1'b0} + 10'(win_e[8]);
        sya = 10'(win_e[0]) + {1'b0, win_e[1], 1'b0} + 10'(win_e[2]);
        syb = 10'(win_e[6]) + {1'b0, win_e[7], 1'b0} + 10'(win_e[8]);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_gx   <= $signed({1'b0, sxa}) - $signed({1'b0, sxb});
            r_gy   <= $signed({1'b0, sya}) - $signed({1'b0, syb});
            r_fend <= fend;
        end
    end

    // fold into the first octant
    logic [9:0]  abs_x, abs_y;
    logic        p_swap;
    logic [20:0] p_n;
    always_comb begin
        abs_x  = r_gx[10] ? 10'(-r_gx) : 10'(r_gx);
        abs_y  = r_gy[10] ? 10'(-r_gy) : 10'(r_gy);
        p_swap = abs_x > abs_y;
        p_n    = 21'(abs_x * abs_x) + 21'(abs_y * abs_y);
    end

    logic [9:0]    r_b;
    logic [10:0]   r_rem;
    logic [QW-1:0] r_q;
    logic [20:0]   r_n;
    logic [10:0]   r_s;
    logic          r_swap, r_zero, r_xneg;

    // restoring division and square root digits, one per cycle
    logic [10:0] d_t;
    logic        d_ge;
    logic [3:0]  sq_sh;
    logic [10:0] sq_c;
    logic [21:0] sq_cc, fx_v;
    always_comb begin
        d_t   = (i_cmd.step == '0) ? r_rem : {r_rem[9:0], 1'b0};
        d_ge  = d_t >= {1'b0, r_b};
        sq_sh = 4'(4'd10 - i_cmd.step[3:0]);
        sq_c  = r_s | (11'd1 << sq_sh);
        sq_cc = 22'(sq_c * sq_c);
        fx_v  = 22'(r_s * r_s) + 22'(r_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_b    <= p_swap ? abs_x : abs_y;
            r_rem  <= {1'b0, p_swap ? abs_y : abs_x};
            r_q    <= '0;
            r_n    <= p_n;
            r_s    <= '0;
            r_swap <= p_swap;
            r_zero <= (r_gx == '0);
            r_xneg <= r_gx[10] ? (!r_gy[10] && r_gy != '0) : r_gy[10];
        end else if (i_cmd.div) begin
            r_rem <= d_ge ? (d_t - {1'b0, r_b}) : d_t;
            r_q   <= {r_q[QW-2:0], d_ge};
            if (i_cmd.step < 6'(SQRT_STEPS) && {1'b0, sq_cc} <= 22'(r_n)) begin
                r_s <= sq_c;
            end
        end else if (i_cmd.fix) begin
            if (22'(r_n) > fx_v) r_s <= r_s + 11'd1;
        end
    end

    // binary search of the tangent table
    logic [9:0]    r_u;
    logic [9:0]    cand;
    logic          cand_ok;
    logic [QW-1:0] r_tan;
    logic          r_cand_ok;
    always_comb begin
        cand    = r_u | (10'd1 << i_cmd.step[3:0]);
        cand_ok = cand <= 10'(OCT_MAX);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_u <= '0;
        end else if (i_cmd.addr) begin
            r_tan     <= TAN_TAB[cand_ok ? cand : 10'd0];
            r_cand_ok <= cand_ok;
        end else if (i_cmd.cmp) begin
            if (r_cand_ok && r_q >= r_tan) r_u <= cand;
        end
    end

    // unfold the angle
    logic [11:0] u0, dir_v;
    logic [11:0] r_dir;
    always_comb begin
        u0 = r_swap ? (DIR_QUARTER - 12'(r_u)) : 12'(r_u);
        if (r_zero)      dir_v = r_xneg ? DIR_HALF : 12'd0;
        else if (r_xneg) dir_v = DIR_HALF - u0;
        else             dir_v = u0;
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.dir) r_dir <= dir_v;
    end

    // output register
    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_magnitude <= r_s;
            o_direction <= r_dir;
            o_frame_end <= r_fend;
        end
    end
    assign o_out_valid    = r_ovalid;
    assign o_sts.out_free = !r_ovalid || i_out_ready;

endmodule
`default_nettype wire

// ----- sv/sobel_gradient_magnitude_angle_unit.sv -----
`default_nettype none
// Sobel 3x3 gradient magnitude and direction over a raster pixel stream.
// s_axis: one pixel per transfer, tdata[7:0] = pixel, tuser = drain (no
// pixel, only advances the stream). m_axis: tdata[10:0] = magnitude,
// tdata[22:11] = direction in sixteenths of a degree (0..2880), tlast
// marks the result of the frame's last pixel.
// Results come one line plus one pixel after their pixel; after a frame,
// frame_width + 1 drain transfers flush the last row.
// APB registers: 0x0 frame_width, 0x4 frame_height. A write restarts the
// frame; write only while the block is idle.
// Processing: an item that yields no result skips the steps below. An item
// with a result goes through a restoring divide of the smaller by the
// larger gradient component, then a 10-step binary search of a registered
// tangent table (an address and a compare state per step); the rounded
// square root runs beside the divide.
// A finished result sits in the output register; the next pixel is taken
// while it waits, and the following result holds until m_axis takes it.
// Reset (synchronous) sets 640 x 480, clears position, window and output valid.
// Line store contents are not cleared; rows not yet written are masked.
module sobel_gradient_magnitude_angle_unit
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  wire logic        s_axis_tuser,   // [0] drain
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [10:0] magnitude, [22:11] direction
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cmd        cmd;
    t_sts        sts;
    logic        cfg_wr;
    logic [11:0] fw, fh;
    logic [10:0] mag;
    logic [11:0] dir;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {20'd0, paddr[2] ? fh : fw};

    sgm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sgm_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_pixel        (s_axis_tdata),
        .i_drain        (s_axis_tuser),
        .i_cfg_wr       (cfg_wr),
        .i_cfg_idx      (paddr[2]),
        .i_cfg_data     (pwdata[11:0]),
        .o_frame_width  (fw),
        .o_frame_height (fh),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_magnitude    (mag),
        .o_direction    (dir),
        .o_frame_end    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, dir, mag};

endmodule
`default_nettype wire

// ----- sv/sgm_checker.sv -----
`default_nettype none
module sgm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // output register is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // one item in flight: input closes after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input open the cycle after a transfer");

    // results stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:0] <= 11'd1443
                           && m_axis_tdata[22:11] <= 12'd2880
                           && !m_axis_tdata[23]))
        else $error("result out of range");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind sobel_gradient_magnitude_angle_unit sgm_checker u_sgm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
